/* src/ubxrx_pkg.sv */
// Shared constants and types for the UBX frame receiver and checker.
// No dependencies; every other file of the block imports this package.
package ubxrx_pkg;

    // Default width of the length counter
    localparam int LENGTH_BITS_DEF = 16;

    // Sync bytes and acknowledge class and ID
    localparam logic [7:0] SYNC_FIRST      = 8'hB5;
    localparam logic [7:0] SYNC_SECOND     = 8'h62;
    localparam logic [7:0] ACK_CLASS       = 8'h05;
    localparam logic [7:0] ACK_ID_POSITIVE = 8'h01;

    // Configuration register indexes
    localparam logic [1:0] CFG_EXPECTED_CLASS  = 2'd0;
    localparam logic [1:0] CFG_EXPECTED_MSG_ID = 2'd1;
    localparam logic [1:0] CFG_MAX_PAYLOAD     = 2'd2;

    // Configuration reset values
    localparam logic [7:0]  EXPECTED_CLASS_RST  = 8'd6;
    localparam logic [7:0]  EXPECTED_MSG_ID_RST = 8'd0;
    localparam logic [15:0] MAX_PAYLOAD_RST     = 16'd256;

    // Receive phase
    typedef enum logic [3:0] {
        PH_SYNC1   = 4'd0,
        PH_SYNC2   = 4'd1,
        PH_CLASS   = 4'd2,
        PH_IDENT   = 4'd3,
        PH_LEN_LO  = 4'd4,
        PH_LEN_HI  = 4'd5,
        PH_PAYLOAD = 4'd6,
        PH_CKA     = 4'd7,
        PH_CKB     = 4'd8
    } phase_t;

    // One finished frame report
    typedef struct packed {
        logic [7:0]  msg_class;
        logic [7:0]  msg_ident;
        logic [15:0] payload_length;
        logic        checksum_ok;
        logic        length_error;
        logic        is_ack_frame;
        logic        ack_positive;
        logic [7:0]  acked_class;
        logic [7:0]  acked_ident;
        logic        matches_expected;
    } result_t;

    // Configuration as seen by the parser
    typedef struct packed {
        logic [7:0]  expected_class;
        logic [7:0]  expected_msg_id;
        logic [15:0] max_payload;
    } cfg_t;

endpackage

/* src/ubxrx_parser.sv */
// Frame parser: sync hunt, header capture, Fletcher-8 sums and frame report.
// Depends on ubxrx_pkg.
module ubxrx_parser
    import ubxrx_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  logic [7:0] rx_byte,
    input  cfg_t       cfg,
    output logic       res_valid,
    output result_t    res
);

    localparam int CW = LENGTH_BITS + 1;

    phase_t                 phase_reg, phase_next;
    logic [7:0]             sum_a_reg, sum_a_next;
    logic [7:0]             sum_b_reg, sum_b_next;
    logic [7:0]             frame_class_reg, frame_class_next;
    logic [7:0]             frame_ident_reg, frame_ident_next;
    logic [15:0]            frame_length_reg, frame_length_next;
    logic [LENGTH_BITS-1:0] bytes_seen_reg, bytes_seen_next;
    logic [15:0]            pair_reg, pair_next;
    logic [7:0]             rx_sum_a_reg, rx_sum_a_next;

    logic [7:0]   sum_a_add, sum_b_add;
    logic [15:0]  len_full;
    logic         len_too_big;
    logic [CW-1:0] seen_inc;
    logic         payload_done;
    logic         ck_ok, is_ack, pair_match;

    // Running sums, full length and payload count
    assign sum_a_add    = sum_a_reg + rx_byte;
    assign sum_b_add    = sum_b_reg + sum_a_add;
    assign len_full     = {rx_byte, frame_length_reg[7:0]};
    assign len_too_big  = (len_full > cfg.max_payload) || ((len_full >> LENGTH_BITS) != 16'd0);
    assign seen_inc     = {1'b0, bytes_seen_reg} + CW'(1);
    assign payload_done = 17'(seen_inc) >= {1'b0, frame_length_reg};

    // Frame-end checks
    assign ck_ok      = (rx_sum_a_reg == sum_a_reg) && (rx_byte == sum_b_reg);
    assign is_ack     = (frame_class_reg == ACK_CLASS);
    assign pair_match = (pair_reg[7:0] == cfg.expected_class)
                        && (pair_reg[15:8] == cfg.expected_msg_id);

    // Next state
    always_comb
    begin
        phase_next        = phase_reg;
        sum_a_next        = sum_a_reg;
        sum_b_next        = sum_b_reg;
        frame_class_next  = frame_class_reg;
        frame_ident_next  = frame_ident_reg;
        frame_length_next = frame_length_reg;
        bytes_seen_next   = bytes_seen_reg;
        pair_next         = pair_reg;
        rx_sum_a_next     = rx_sum_a_reg;
        if (fire)
        begin
            unique case (phase_reg)
                PH_SYNC2:
                begin
                    if (rx_byte == SYNC_SECOND)
                        phase_next = PH_CLASS;
                    else if (rx_byte != SYNC_FIRST)
                        phase_next = PH_SYNC1;
                end
                PH_CLASS:
                begin
                    sum_a_next        = rx_byte;
                    sum_b_next        = rx_byte;
                    frame_class_next  = rx_byte;
                    frame_ident_next  = 8'd0;
                    frame_length_next = 16'd0;
                    bytes_seen_next   = '0;
                    pair_next         = 16'd0;
                    rx_sum_a_next     = 8'd0;
                    phase_next        = PH_IDENT;
                end
                PH_IDENT:
                begin
                    sum_a_next       = sum_a_add;
                    sum_b_next       = sum_b_add;
                    frame_ident_next = rx_byte;
                    phase_next       = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    sum_a_next        = sum_a_add;
                    sum_b_next        = sum_b_add;
                    frame_length_next = {8'd0, rx_byte};
                    phase_next        = PH_LEN_HI;
                end
                PH_LEN_HI:
                begin
                    sum_a_next        = sum_a_add;
                    sum_b_next        = sum_b_add;
                    frame_length_next = len_full;
                    if (len_too_big)
                        phase_next = PH_SYNC1;
                    else if (len_full == 16'd0)
                        phase_next = PH_CKA;
                    else
                        phase_next = PH_PAYLOAD;
                end
                PH_PAYLOAD:
                begin
                    sum_a_next = sum_a_add;
                    sum_b_next = sum_b_add;
                    if (bytes_seen_reg == '0)
                        pair_next = {pair_reg[15:8], rx_byte};
                    else if (bytes_seen_reg == LENGTH_BITS'(1))
                        pair_next = {rx_byte, pair_reg[7:0]};
                    bytes_seen_next = seen_inc[LENGTH_BITS-1:0];
                    if (payload_done)
                        phase_next = PH_CKA;
                end
                PH_CKA:
                begin
                    rx_sum_a_next = rx_byte;
                    phase_next    = PH_CKB;
                end
                PH_CKB:
                begin
                    phase_next = PH_SYNC1;
                end
                default:
                begin
                    phase_next = (rx_byte == SYNC_FIRST) ? PH_SYNC2 : PH_SYNC1;
                end
            endcase
        end
    end

    // Frame report
    always_comb
    begin
        res_valid            = 1'b0;
        res.msg_class        = frame_class_reg;
        res.msg_ident        = frame_ident_reg;
        res.payload_length   = frame_length_reg;
        res.checksum_ok      = 1'b0;
        res.length_error     = 1'b0;
        res.is_ack_frame     = 1'b0;
        res.ack_positive     = 1'b0;
        res.acked_class      = 8'd0;
        res.acked_ident      = 8'd0;
        res.matches_expected = 1'b0;
        unique case (phase_reg)
            PH_LEN_HI:
            begin
                res_valid          = len_too_big;
                res.payload_length = len_full;
                res.length_error   = 1'b1;
            end
            PH_CKB:
            begin
                res_valid            = 1'b1;
                res.checksum_ok      = ck_ok;
                res.is_ack_frame     = is_ack;
                res.ack_positive     = is_ack && (frame_ident_reg == ACK_ID_POSITIVE);
                res.acked_class      = pair_reg[7:0];
                res.acked_ident      = pair_reg[15:8];
                res.matches_expected = ck_ok && is_ack && (frame_length_reg >= 16'd2)
                                       && pair_match;
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_SYNC1;
            sum_a_reg        <= 8'd0;
            sum_b_reg        <= 8'd0;
            frame_class_reg  <= 8'd0;
            frame_ident_reg  <= 8'd0;
            frame_length_reg <= 16'd0;
            bytes_seen_reg   <= '0;
            pair_reg         <= 16'd0;
            rx_sum_a_reg     <= 8'd0;
        end
        else
        begin
            phase_reg        <= phase_next;
            sum_a_reg        <= sum_a_next;
            sum_b_reg        <= sum_b_next;
            frame_class_reg  <= frame_class_next;
            frame_ident_reg  <= frame_ident_next;
            frame_length_reg <= frame_length_next;
            bytes_seen_reg   <= bytes_seen_next;
            pair_reg         <= pair_next;
            rx_sum_a_reg     <= rx_sum_a_next;
        end
    end

    // A match needs a good checksum on an acknowledge frame
    a_match_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.matches_expected |-> res.checksum_ok && res.is_ack_frame)
        else $error("match reported without good acknowledge frame");

    // An abandoned frame carries no checksum verdict
    a_len_err_no_ck: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.length_error |-> !res.checksum_ok && !res.is_ack_frame)
        else $error("length error report carries frame flags");

    // Every delivered report restarts the sync hunt
    a_report_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res_valid |=> phase_reg == PH_SYNC1)
        else $error("hunt not restarted after frame report");

endmodule

/* src/ubxrx_out_reg.sv */
// Output register holding one frame report until the consumer takes it.
// Depends on ubxrx_pkg.
module ubxrx_out_reg
    import ubxrx_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t load_data,
    input  logic    out_ready,
    output logic    out_valid,
    output logic    slot_free,
    output result_t data
);

    logic    valid_reg, valid_next;
    result_t data_reg;

    // Free when empty or being drained this cycle
    assign slot_free = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
    end

    // Hold valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Capture the report word
    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= load_data;
    end

    assign out_valid = valid_reg;
    assign data      = data_reg;

endmodule

/* src/ubx_frame_receiver_checker.sv */
// Top level of the UBX frame receiver and acknowledge checker.
// Depends on ubxrx_pkg, ubxrx_parser and ubxrx_out_reg.
//
// Takes one received byte per cycle while in_ready is high and emits one
// report word per finished UBX frame (or per frame abandoned for an oversized
// length). The parser state and the Fletcher-8 add pair update with each
// accepted byte; a report lands in the output register on the next edge. A
// byte is accepted whenever the output register is empty or being read in the
// same cycle, so a stalled consumer holds input only while a report waits.
// Configuration writes take effect on the next edge and should be made idle.
module ubx_frame_receiver_checker
    import ubxrx_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  msg_class,
    output logic [7:0]  msg_ident,
    output logic [15:0] payload_length,
    output logic        checksum_ok,
    output logic        length_error,
    output logic        is_ack_frame,
    output logic        ack_positive,
    output logic [7:0]  acked_class,
    output logic [7:0]  acked_ident,
    output logic        matches_expected
);

    cfg_t    cfg_reg;
    logic    in_fire;
    logic    res_valid;
    result_t res;
    result_t out_data;
    logic    slot_free;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.expected_class  <= EXPECTED_CLASS_RST;
            cfg_reg.expected_msg_id <= EXPECTED_MSG_ID_RST;
            cfg_reg.max_payload     <= MAX_PAYLOAD_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_EXPECTED_CLASS:  cfg_reg.expected_class  <= cfg_wdata[7:0];
                CFG_EXPECTED_MSG_ID: cfg_reg.expected_msg_id <= cfg_wdata[7:0];
                CFG_MAX_PAYLOAD:     cfg_reg.max_payload     <= cfg_wdata;
                default:             cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    // Accept a byte when the report slot can take a result
    assign in_ready = slot_free;
    assign in_fire  = in_valid && slot_free;

    ubxrx_parser #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (in_fire),
        .rx_byte   (rx_byte),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    ubxrx_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (in_fire && res_valid),
        .load_data (res),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .slot_free (slot_free),
        .data      (out_data)
    );

    // Unpack the report word
    assign msg_class        = out_data.msg_class;
    assign msg_ident        = out_data.msg_ident;
    assign payload_length   = out_data.payload_length;
    assign checksum_ok      = out_data.checksum_ok;
    assign length_error     = out_data.length_error;
    assign is_ack_frame     = out_data.is_ack_frame;
    assign ack_positive     = out_data.ack_positive;
    assign acked_class      = out_data.acked_class;
    assign acked_ident      = out_data.acked_ident;
    assign matches_expected = out_data.matches_expected;

endmodule
